@@ hw/rtl/quadtree_image_decoder_assert.svh @@
// assertion macros used by the decoder datapath
`ifndef QUADTREE_IMAGE_DECODER_ASSERT_SVH
`define QUADTREE_IMAGE_DECODER_ASSERT_SVH

// same-cycle implication, muted while in reset
`define QID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quadtree decoder check failed");

// next-cycle implication, muted while in reset
`define QID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quadtree decoder check failed");

`endif

@@ hw/rtl/qid_pkg.sv @@
// shared types and constants of the quadtree image decoder
`timescale 1ns / 1ps

package qid_pkg;

  localparam int CW = 11;
  localparam logic [7:0] LEAF_MARK = 8'h4E;
  localparam logic [1:0] LAST_CHILD = 2'd3;

  typedef struct packed {
    logic [CW-1:0] left;
    logic [CW-1:0] top;
    logic [CW-1:0] right;
    logic [CW-1:0] bottom;
  } region_t;

  typedef struct packed {
    region_t    parent;
    logic [1:0] child;
  } frame_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_MARK,
    OP_PUSH,
    OP_OVERFLOW,
    OP_RED,
    OP_GREEN,
    OP_LEAF,
    OP_POP_READ,
    OP_POP_STEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } qid_cmd_t;

  typedef struct packed {
    logic [1:0] colour_cnt;
    logic       byte_is_mark;
    logic       lvl_full;
    logic       lvl_zero;
    logic       lvl_one;
    logic       child_last;
    logic       out_free;
  } qid_status_t;

endpackage

@@ hw/rtl/quadtree_image_decoder.sv @@
// top level of the quadtree image decoder
//
//   port group  direction  carries
//   in_*        in         one stream byte per item
//   out_*       out        one fill rectangle with colour and flags per item
//   cfg_*       in         image side register write, always ready
//
// a byte is taken in the idle state and decoded in the sequencer's decode state
// a blue byte or an overflowing split also passes the emit state to load the output register
// a blue byte below the top level first walks back up the stack, through a read and
// a check state per stack level read on the way up (registered stack read)
// the output register lets new bytes in while a result waits; the sequencer
// holds in its emit state only when a new result meets an untaken one
// synchronous reset: side 256, empty stack, whole image as current region
`timescale 1ns / 1ps

module quadtree_image_decoder #(
  parameter int MAX_SIDE    = 1024,
  parameter int STACK_DEPTH = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_stream_byte,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [qid_pkg::CW-1:0] cfg_image_side,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [qid_pkg::CW-1:0] out_fill_left,
  output logic [qid_pkg::CW-1:0] out_fill_top,
  output logic [qid_pkg::CW-1:0] out_fill_right,
  output logic [qid_pkg::CW-1:0] out_fill_bottom,
  output logic [7:0]             out_red,
  output logic [7:0]             out_green,
  output logic [7:0]             out_blue,
  output logic                   out_tree_done,
  output logic                   out_overflow
);
  import qid_pkg::*;

  qid_cmd_t    cmd;
  qid_status_t status;

  assign cfg_ready = 1'b1;

  qid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  qid_dp #(
    .MAX_SIDE    (MAX_SIDE),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_stream_byte  (in_stream_byte),
    .cfg_we          (cfg_valid),
    .cfg_image_side  (cfg_image_side),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_fill_left   (out_fill_left),
    .out_fill_top    (out_fill_top),
    .out_fill_right  (out_fill_right),
    .out_fill_bottom (out_fill_bottom),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_tree_done   (out_tree_done),
    .out_overflow    (out_overflow)
  );

endmodule

@@ hw/rtl/qid_ctrl.sv @@
// sequencer: decodes each byte and walks the stack back up after a leaf
`timescale 1ns / 1ps

module qid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qid_pkg::qid_status_t status,
  output qid_pkg::qid_cmd_t   cmd
);
  import qid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RD,
    S_POP_CHK,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_TAKE;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.colour_cnt)
          2'd0: begin
            priority if (status.byte_is_mark) begin
              cmd.op    = OP_MARK;
              state_nxt = S_IDLE;
            end else if (status.lvl_full) begin
              cmd.op    = OP_OVERFLOW;
              state_nxt = S_EMIT;
            end else begin
              cmd.op    = OP_PUSH;
              state_nxt = S_IDLE;
            end
          end
          2'd1: begin
            cmd.op    = OP_RED;
            state_nxt = S_IDLE;
          end
          2'd2: begin
            cmd.op    = OP_GREEN;
            state_nxt = S_IDLE;
          end
          default: begin
            cmd.op    = OP_LEAF;
            state_nxt = status.lvl_zero ? S_EMIT : S_POP_RD;
          end
        endcase
      end
      S_POP_RD: begin
        cmd.op    = OP_POP_READ;
        state_nxt = S_POP_CHK;
      end
      S_POP_CHK: begin
        cmd.op = OP_POP_STEP;
        // a finished parent with more levels above needs another read
        state_nxt = (status.child_last && !status.lvl_one) ? S_POP_RD : S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

@@ hw/rtl/qid_dp.sv @@
// datapath: traversal registers, region stack, result staging and output register
`timescale 1ns / 1ps
`include "quadtree_image_decoder_assert.svh"

module qid_dp #(
  parameter int MAX_SIDE    = 1024,
  parameter int STACK_DEPTH = 12
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  qid_pkg::qid_cmd_t         cmd,
  output qid_pkg::qid_status_t      status,
  input  logic [7:0]                in_stream_byte,
  input  logic                      cfg_we,
  input  logic [qid_pkg::CW-1:0]    cfg_image_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [qid_pkg::CW-1:0]    out_fill_left,
  output logic [qid_pkg::CW-1:0]    out_fill_top,
  output logic [qid_pkg::CW-1:0]    out_fill_right,
  output logic [qid_pkg::CW-1:0]    out_fill_bottom,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic                      out_tree_done,
  output logic                      out_overflow
);
  import qid_pkg::*;

  localparam int LVL_W    = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W    = $clog2(STACK_DEPTH);
  localparam int SIDE_CAP = (MAX_SIDE > 2047) ? 2047 : MAX_SIDE;
  localparam logic [CW-1:0]    SIDE_RESET = CW'(256);
  localparam logic [LVL_W-1:0] LVL_MAX    = LVL_W'(STACK_DEPTH);

  function automatic region_t whole_image(input logic [CW-1:0] side);
    logic [CW-1:0] s;
    region_t       r;
    s        = (32'(side) > 32'(SIDE_CAP)) ? CW'(SIDE_CAP) : side;
    r.left   = '0;
    r.top    = '0;
    r.right  = s;
    r.bottom = s;
    return r;
  endfunction

  // split at start plus half the length, child bit 0 picks right, bit 1 bottom
  function automatic region_t quadrant(input region_t p, input logic [1:0] q);
    logic [CW-1:0] mx;
    logic [CW-1:0] my;
    region_t       r;
    mx       = p.left + ((p.right - p.left) >> 1);
    my       = p.top + ((p.bottom - p.top) >> 1);
    r.left   = q[0] ? mx : p.left;
    r.right  = q[0] ? p.right : mx;
    r.top    = q[1] ? my : p.top;
    r.bottom = q[1] ? p.bottom : my;
    return r;
  endfunction

  logic [CW-1:0]    side_r;
  logic [7:0]       byte_r;
  logic [1:0]       cnt_r;
  logic [LVL_W-1:0] lvl_r;
  region_t          cur_r;
  logic [7:0]       held_red_r;
  logic [7:0]       held_green_r;
  frame_t           rd_r;

  region_t          stg_rect_r;
  logic [7:0]       stg_red_r;
  logic [7:0]       stg_green_r;
  logic [7:0]       stg_blue_r;
  logic             stg_done_r;
  logic             stg_ovf_r;

  logic             out_valid_r;
  region_t          out_rect_r;
  logic [7:0]       out_red_r;
  logic [7:0]       out_green_r;
  logic [7:0]       out_blue_r;
  logic             out_done_r;
  logic             out_ovf_r;

  frame_t           stack_mem [STACK_DEPTH];
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  frame_t           wr_data;
  logic [LVL_W-1:0] lvl_dec;
  logic [IDX_W-1:0] top_idx;
  logic [1:0]       next_child;
  logic             out_free;

  assign lvl_dec    = lvl_r - LVL_W'(1);
  assign top_idx    = lvl_dec[IDX_W-1:0];
  assign next_child = rd_r.child + 2'd1;
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = top_idx;
    wr_data = rd_r;
    unique case (cmd.op)
      OP_PUSH: begin
        wr_en          = 1'b1;
        wr_idx         = lvl_r[IDX_W-1:0];
        wr_data.parent = cur_r;
        wr_data.child  = 2'd0;
      end
      OP_POP_STEP: begin
        wr_en         = (rd_r.child != LAST_CHILD);
        wr_data.child = next_child;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_idx] <= wr_data;
    end
    if (cmd.op == OP_POP_READ) begin
      rd_r <= stack_mem[top_idx];
    end
  end

  // traversal state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r       <= SIDE_RESET;
      cnt_r        <= 2'd0;
      lvl_r        <= '0;
      cur_r        <= whole_image(SIDE_RESET);
      held_red_r   <= 8'd0;
      held_green_r <= 8'd0;
    end else begin
      unique case (cmd.op)
        OP_MARK: cnt_r <= 2'd1;
        OP_PUSH: begin
          lvl_r <= lvl_r + LVL_W'(1);
          cur_r <= quadrant(cur_r, 2'd0);
        end
        OP_OVERFLOW: begin
          lvl_r <= '0;
          cnt_r <= 2'd0;
          cur_r <= whole_image(side_r);
        end
        OP_RED: begin
          held_red_r <= byte_r;
          cnt_r      <= 2'd2;
        end
        OP_GREEN: begin
          held_green_r <= byte_r;
          cnt_r        <= 2'd3;
        end
        OP_LEAF: begin
          cnt_r <= 2'd0;
          if (lvl_r == '0) begin
            cur_r <= whole_image(side_r);
          end
        end
        OP_POP_STEP: begin
          priority if (rd_r.child != LAST_CHILD) begin
            cur_r <= quadrant(rd_r.parent, next_child);
          end else if (lvl_r == LVL_W'(1)) begin
            lvl_r <= '0;
            cur_r <= whole_image(side_r);
          end else begin
            lvl_r <= lvl_dec;
          end
        end
        default: ;
      endcase
      if (cfg_we) begin
        side_r <= cfg_image_side;
        // reloads the region only between images
        if (lvl_r == '0 && cnt_r == 2'd0) begin
          cur_r <= whole_image(cfg_image_side);
        end
      end
    end
  end

  // input byte and result staging
  always_ff @(posedge clk) begin
    if (cmd.op == OP_TAKE) begin
      byte_r <= in_stream_byte;
    end
    unique case (cmd.op)
      OP_OVERFLOW: begin
        stg_rect_r  <= '0;
        stg_red_r   <= 8'd0;
        stg_green_r <= 8'd0;
        stg_blue_r  <= 8'd0;
        stg_done_r  <= 1'b0;
        stg_ovf_r   <= 1'b1;
      end
      OP_LEAF: begin
        stg_rect_r  <= cur_r;
        stg_red_r   <= held_red_r;
        stg_green_r <= held_green_r;
        stg_blue_r  <= byte_r;
        stg_done_r  <= (lvl_r == '0);
        stg_ovf_r   <= 1'b0;
      end
      OP_POP_STEP: begin
        stg_done_r <= (rd_r.child == LAST_CHILD) && (lvl_r == LVL_W'(1));
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      priority if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.op == OP_EMIT) begin
      out_rect_r  <= stg_rect_r;
      out_red_r   <= stg_red_r;
      out_green_r <= stg_green_r;
      out_blue_r  <= stg_blue_r;
      out_done_r  <= stg_done_r;
      out_ovf_r   <= stg_ovf_r;
    end
  end

  assign status.colour_cnt   = cnt_r;
  assign status.byte_is_mark = (byte_r == LEAF_MARK);
  assign status.lvl_full     = (lvl_r == LVL_MAX);
  assign status.lvl_zero     = (lvl_r == '0);
  assign status.lvl_one      = (lvl_r == LVL_W'(1));
  assign status.child_last   = (rd_r.child == LAST_CHILD);
  assign status.out_free     = out_free;

  assign out_valid       = out_valid_r;
  assign out_fill_left   = out_rect_r.left;
  assign out_fill_top    = out_rect_r.top;
  assign out_fill_right  = out_rect_r.right;
  assign out_fill_bottom = out_rect_r.bottom;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_tree_done   = out_done_r;
  assign out_overflow    = out_ovf_r;

  `QID_ASSERT_NOW(a_lvl_in_range, clk, rst_n, 1'b1, lvl_r <= LVL_MAX)
  `QID_ASSERT_NOW(a_push_not_full, clk, rst_n, cmd.op == OP_PUSH, lvl_r != LVL_MAX)
  `QID_ASSERT_NOW(a_pop_has_frame, clk, rst_n, cmd.op == OP_POP_STEP, lvl_r != '0)
  `QID_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.op == OP_EMIT, out_valid_r)
  `QID_ASSERT_NOW(a_overflow_blank, clk, rst_n, out_valid_r && out_ovf_r,
                  !out_done_r && out_rect_r.right == '0 && out_rect_r.bottom == '0)

endmodule
